// ===== src/tccw_pkg.sv =====
package tccw_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int IDX_W      = 11;
    localparam int CURSOR_W   = 11;
    localparam int WORD_W     = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FG = 1'b0,
        REG_BG = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic put_char;
        logic newline;
        logic home;
    } t_cursor_op;

    function automatic logic [WORD_W-1:0] make_cell(
        input logic [COLOR_W-1:0] bg,
        input logic [COLOR_W-1:0] fg,
        input logic [CHAR_W-1:0]  ch
    );
        return {bg, fg, ch};
    endfunction

endpackage

// ===== src/tccw_screen_ram.sv =====
module tccw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [tccw_pkg::WORD_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [tccw_pkg::WORD_W-1:0] o_rdata
);
    import tccw_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tccw_cursor_unit.sv =====
module tccw_cursor_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tccw_pkg::t_cursor_op  i_op,
    output logic [ADDR_W-1:0]     o_cursor,
    output logic [ADDR_W-1:0]     o_cursor_next,
    output logic                  o_wrap
);
    import tccw_pkg::*;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              col_last, row_last, wrap;
    logic [ADDR_W:0]   nl_sum;

    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign nl_sum   = {1'b0, r_cursor} - (ADDR_W+1)'(r_col) + (ADDR_W+1)'(COLUMNS);

    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_row    = r_row;
        wrap     = 1'b0;
        if (i_op.home) begin
            n_cursor = '0;
            n_col    = '0;
            n_row    = '0;
        end else if (i_op.put_char) begin
            n_cursor = r_cursor + ADDR_W'(1);
            if (col_last) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
                wrap  = row_last;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else if (i_op.newline) begin
            n_cursor = nl_sum[ADDR_W-1:0];
            n_col    = '0;
            n_row    = r_row + ROW_W'(1);
            wrap     = row_last;
        end
        if (wrap) begin
            n_cursor = '0;
            n_col    = '0;
            n_row    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    assign o_cursor      = r_cursor;
    assign o_cursor_next = n_cursor;
    assign o_wrap        = wrap;

    a_cursor_matches_row_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) == 32'(r_row) * 32'(COLUMNS) + 32'(r_col))
        else $error("cursor out of step with row and column");

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < 32'(COLUMNS)) && (32'(r_row) < 32'(ROWS)))
        else $error("cursor outside screen");

endmodule

// ===== src/text_console_cell_writer.sv =====
// Text console cell writer. Holds a ROWS x COLUMNS screen of 16-bit cells
// ({background, foreground, character}) in a single-port-write, registered-
// read memory, plus a cursor. A put or newline transaction can be followed
// right away by the next one while the output is not stalled; a read goes
// through the registered memory read port and then the output register, and
// no new transaction is taken meanwhile. A clear command, or a put that moves
// the cursor past the last cell, sweeps the blank word through the memory one
// cell per cycle, and the input is held off meanwhile. The memory is not
// cleared at reset: reading a cell before any put or clear has written it
// returns garbage. Reads at or past ROWS*COLUMNS return zero.
module text_console_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config: index 0 foreground color, index 1 background color
    input  logic                            i_cfg_wen,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]    i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // char_code[7:0], color_override[8], override_fg[12:9],
    // override_bg[16:13], cell_index[27:17], zero[31:28]
    input  logic [tccw_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // command[1:0]
    input  logic [tccw_pkg::CMD_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // cell_word[15:0], cursor_pos[26:16], screen_cleared[27], zero[31:28]
    output logic [tccw_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import tccw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [COLOR_W-1:0]   r_fg, r_bg;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_W-1:0]    r_out_word, n_out_word;
    logic [CURSOR_W-1:0]  r_out_cursor, n_out_cursor;
    logic                 r_out_cleared, n_out_cleared;
    logic [WORD_W-1:0]    r_blank, n_blank;
    logic [ADDR_W-1:0]    r_sweep, n_sweep;
    logic                 r_rd_oob, n_rd_oob;

    logic                 s_acc;
    t_cmd                 cmd;
    logic [CHAR_W-1:0]    in_char;
    logic                 in_ovr;
    logic [COLOR_W-1:0]   in_fg, in_bg, eff_fg, eff_bg;
    logic [IDX_W-1:0]     in_idx;
    logic [31:0]          idx32;
    logic                 idx_oob;
    logic                 out_load;

    t_cursor_op           cur_op;
    logic [ADDR_W-1:0]    cursor, cursor_next;
    logic [31:0]          cursor32, cursor_next32;
    logic                 wrap;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;

    assign cmd     = t_cmd'(i_s_axis_tuser);
    assign in_char = i_s_axis_tdata[7:0];
    assign in_ovr  = i_s_axis_tdata[8];
    assign in_fg   = i_s_axis_tdata[12:9];
    assign in_bg   = i_s_axis_tdata[16:13];
    assign in_idx  = i_s_axis_tdata[27:17];
    assign eff_fg  = in_ovr ? in_fg : r_fg;
    assign eff_bg  = in_ovr ? in_bg : r_bg;
    assign idx32   = 32'(in_idx);
    assign idx_oob = (idx32 >= 32'(CELLS));

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign cur_op.put_char = s_acc && (cmd == CMD_PUT) && (in_char != NEWLINE_CODE);
    assign cur_op.newline  = s_acc && (cmd == CMD_PUT) && (in_char == NEWLINE_CODE);
    assign cur_op.home     = s_acc && (cmd == CMD_CLEAR);

    tccw_cursor_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (cur_op),
        .o_cursor      (cursor),
        .o_cursor_next (cursor_next),
        .o_wrap        (wrap)
    );

    assign cursor32      = 32'(cursor);
    assign cursor_next32 = 32'(cursor_next);

    assign ram_we    = cur_op.put_char || (r_state == S_CLEAR);
    assign ram_waddr = (r_state == S_CLEAR) ? r_sweep : cursor;
    assign ram_wdata = (r_state == S_CLEAR) ? r_blank : make_cell(eff_bg, eff_fg, in_char);
    assign ram_re    = s_acc && (cmd == CMD_READ);

    tccw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (idx32[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_out_word    = r_out_word;
        n_out_cursor  = r_out_cursor;
        n_out_cleared = r_out_cleared;
        n_blank       = r_blank;
        n_sweep       = r_sweep;
        n_rd_oob      = r_rd_oob;
        out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (cmd)
                        CMD_PUT: begin
                            if (wrap) begin
                                n_blank = make_cell(eff_bg, eff_fg, '0);
                                n_sweep = '0;
                                n_state = S_CLEAR;
                            end else begin
                                out_load      = 1'b1;
                                n_out_word    = '0;
                                n_out_cursor  = cursor_next32[CURSOR_W-1:0];
                                n_out_cleared = 1'b0;
                            end
                        end
                        CMD_CLEAR: begin
                            n_blank = make_cell(eff_bg, eff_fg, '0);
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_READ: begin
                            n_rd_oob = idx_oob;
                            n_state  = S_READ;
                        end
                        default: begin
                            out_load      = 1'b1;
                            n_out_word    = '0;
                            n_out_cursor  = cursor32[CURSOR_W-1:0];
                            n_out_cleared = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                out_load      = 1'b1;
                n_out_word    = r_rd_oob ? '0 : ram_rdata;
                n_out_cursor  = cursor32[CURSOR_W-1:0];
                n_out_cleared = 1'b0;
                n_state       = S_IDLE;
            end
            S_CLEAR: begin
                if (r_sweep == ADDR_W'(CELLS - 1)) begin
                    out_load      = 1'b1;
                    n_out_word    = '0;
                    n_out_cursor  = '0;
                    n_out_cleared = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_m_axis_tready) || out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fg        <= 4'd15;
            r_bg        <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_FG:  r_fg <= i_cfg_data;
                    REG_BG:  r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word    <= n_out_word;
        r_out_cursor  <= n_out_cursor;
        r_out_cleared <= n_out_cleared;
        r_blank       <= n_blank;
        r_sweep       <= n_sweep;
        r_rd_oob      <= n_rd_oob;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_cleared, r_out_cursor, r_out_word};

    a_sweep_no_pending_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result pending during clear sweep");

    a_read_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (cmd == CMD_READ)) |=> ((r_state == S_READ) ##1 r_out_valid))
        else $error("read result not produced on time");

    a_cleared_homes_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cleared) |-> (r_out_cursor == '0) && (r_out_word == '0))
        else $error("clear result with nonzero cursor or word");

endmodule
